// ----- hw/rtl/rmt_pkg.sv -----
// Shared types and codes for the randomized multiset table.
// Depends on nothing; imported by the top level.
package rmt_pkg;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned BIT_CNT_W = $clog2(VAL_W);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NOP    = 2'd3
  } rmt_cmd_e;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_SEARCH  = 8'b0000_0010,
    ST_MV_RD   = 8'b0000_0100,
    ST_MV_WR   = 8'b0000_1000,
    ST_MOD     = 8'b0001_0000,
    ST_SMP_RD  = 8'b0010_0000,
    ST_SMP_CAP = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } rmt_state_e;

  typedef struct packed {
    logic                    success;
    logic                    full_error;
    logic                    empty_error;
    logic signed [VAL_W-1:0] sample_value;
  } rmt_result_t;

endpackage

// ----- hw/rtl/randomized_multiset_table.sv -----
// Bounded multiset of signed 32-bit values in one synchronous table memory.
// Depends on rmt_pkg for command codes, state codes and the result word.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+-----------------------------------
//   in      | input     | in_valid_i/in_stall_o   | command_i, value_i, random_word_i
//   out     | output    | out_valid_o/out_stall_i | success_o, full_error_o,
//           |           |                         |   empty_error_o, sample_value_o
//
// One item at a time. Insert and remove scan the table one entry per cycle
// through the single read port; a remove that finds its value moves the last
// entry into the hole. Sample runs a one-bit-per-cycle remainder of
// random_word_i by the live count. Full insert, empty sample and the unused
// code go straight to the result.
// Reset clears the live count; the table needs no clearing pass.
// The output word sits in its own register, so the next item is accepted
// while a result waits; a stalled result only holds back the finish of the next.
module randomized_multiset_table #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        command_i,
  input  logic signed [rmt_pkg::VAL_W-1:0]  value_i,
  input  logic [rmt_pkg::VAL_W-1:0]         random_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              success_o,
  output logic                              full_error_o,
  output logic                              empty_error_o,
  output logic signed [rmt_pkg::VAL_W-1:0]  sample_value_o
);
  import rmt_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // table memory, one write and one registered read port
  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rd_data_q;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_data;

  rmt_state_e              state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  rmt_cmd_e                cmd_q, cmd_d;
  logic signed [VAL_W-1:0] value_q, value_d;
  logic [CW-1:0]           scan_q, scan_d;
  logic                    chk_vld_q, chk_vld_d;
  logic [AW-1:0]           chk_idx_q, chk_idx_d;
  logic [AW-1:0]           slot_q, slot_d;
  logic [CW-1:0]           rem_q, rem_d;
  logic [VAL_W-1:0]        dvd_q, dvd_d;
  logic [BIT_CNT_W-1:0]    bit_cnt_q, bit_cnt_d;
  rmt_result_t             res_q, res_d;
  rmt_result_t             out_q;
  logic                    out_valid_q;
  logic                    out_load;

  logic                    in_accept;
  logic                    is_full;
  logic                    hit;
  logic [CW-1:0]           last_idx;
  logic [CW:0]             mod_trial;
  logic [CW:0]             mod_diff;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign is_full = (count_q == CW'(CAPACITY));
  assign hit = chk_vld_q && (rd_data_q == value_q);
  assign last_idx = count_q - CW'(1);
  assign mod_trial = {rem_q, dvd_q[VAL_W-1]};
  assign mod_diff = mod_trial - {1'b0, count_q};

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cmd_d     = cmd_q;
    value_d   = value_q;
    scan_d    = scan_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    slot_d    = slot_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    bit_cnt_d = bit_cnt_q;
    res_d     = res_q;
    rd_addr   = scan_q[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = count_q[AW-1:0];
    wr_data   = value_q;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_d     = rmt_cmd_e'(command_i);
          value_d   = value_i;
          dvd_d     = random_word_i;
          scan_d    = '0;
          rem_d     = '0;
          bit_cnt_d = '1;
          res_d     = '0;
          case (rmt_cmd_e'(command_i))
            CMD_INSERT: begin
              if (is_full) begin
                res_d.full_error = 1'b1;
                state_d = ST_DONE;
              end else begin
                state_d = ST_SEARCH;
              end
            end
            CMD_REMOVE: state_d = ST_SEARCH;
            CMD_SAMPLE: begin
              if (count_q == '0) begin
                res_d.empty_error = 1'b1;
                state_d = ST_DONE;
              end else begin
                state_d = ST_MOD;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_SEARCH: begin
        // issue the next read while comparing the word read last cycle
        if (scan_q < count_q) begin
          chk_vld_d = 1'b1;
          chk_idx_d = scan_q[AW-1:0];
          scan_d    = scan_q + CW'(1);
        end
        if (hit || (scan_q >= count_q)) begin
          if (cmd_q == CMD_INSERT) begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
            res_d.success = !hit;
            state_d = ST_DONE;
          end else if (hit) begin
            slot_d  = chk_idx_q;
            state_d = ST_MV_RD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_MV_RD: begin
        rd_addr = last_idx[AW-1:0];
        state_d = ST_MV_WR;
      end

      ST_MV_WR: begin
        // fill the hole with the last entry and shrink
        wr_en   = 1'b1;
        wr_addr = slot_q;
        wr_data = rd_data_q;
        count_d = last_idx;
        res_d.success = 1'b1;
        state_d = ST_DONE;
      end

      ST_MOD: begin
        rem_d     = mod_diff[CW] ? mod_trial[CW-1:0] : mod_diff[CW-1:0];
        dvd_d     = {dvd_q[VAL_W-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - BIT_CNT_W'(1);
        if (bit_cnt_q == '0) begin
          state_d = ST_SMP_RD;
        end
      end

      ST_SMP_RD: begin
        rd_addr = rem_q[AW-1:0];
        state_d = ST_SMP_CAP;
      end

      ST_SMP_CAP: begin
        res_d.sample_value = rd_data_q;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      chk_vld_q <= chk_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    value_q   <= value_d;
    scan_q    <= scan_d;
    chk_idx_q <= chk_idx_d;
    slot_q    <= slot_d;
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    bit_cnt_q <= bit_cnt_d;
    res_q     <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign success_o      = out_q.success;
  assign full_error_o   = out_q.full_error;
  assign empty_error_o  = out_q.empty_error;
  assign sample_value_o = out_q.sample_value;

endmodule

// ----- hw/rtl/rmt_checker.sv -----
// Port-level checks for the randomized multiset table.
// Depends on nothing; bound to randomized_multiset_table below.
module rmt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         command_i,
  input logic signed [31:0] value_i,
  input logic [31:0]        random_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               success_o,
  input logic               full_error_o,
  input logic               empty_error_o,
  input logic signed [31:0] sample_value_o
);

  // the block works on one word at a time
  busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item was in progress");

  out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(success_o) &&
      $stable(full_error_o) && $stable(empty_error_o) && $stable(sample_value_o)))
    else $error("stalled result word changed");

  flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({success_o, full_error_o, empty_error_o}))
    else $error("more than one status flag set");

  error_no_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (full_error_o || empty_error_o)) |-> (sample_value_o == 32'sd0))
    else $error("sample value on an error result");

  success_no_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && success_o) |-> (sample_value_o == 32'sd0))
    else $error("sample value on an insert or remove result");

endmodule

bind randomized_multiset_table rmt_checker u_rmt_checker (.*);

// ----- verif/randomized_multiset_table_test.sv -----
// Self-checking testbench for the randomized multiset table.
// Depends on rmt_pkg and randomized_multiset_table; predicts every result word
// from its own copy of the table and checks it against the output channel.
`timescale 1ns / 100ps

module randomized_multiset_table_test;
  import rmt_pkg::*;

  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned TAIL_OPS   = 150;
  localparam int unsigned DRAIN_WAIT = CAPACITY + 50;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned HOLD_AT    = 500;
  localparam int unsigned POOL_SIZE  = 12;

  typedef struct {
    rmt_cmd_e                cmd;
    logic signed [VAL_W-1:0] value;
    logic [VAL_W-1:0]        rnd;
    bit                      drain;
  } table_op_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              command_i     = CMD_NOP;
  logic signed [VAL_W-1:0] value_i       = '0;
  logic [VAL_W-1:0]        random_word_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic                    success_o;
  logic                    full_error_o;
  logic                    empty_error_o;
  logic signed [VAL_W-1:0] sample_value_o;

  randomized_multiset_table #(.CAPACITY(CAPACITY)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .random_word_i  (random_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .success_o      (success_o),
    .full_error_o   (full_error_o),
    .empty_error_o  (empty_error_o),
    .sample_value_o (sample_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  table_op_t               pending_ops[$];
  rmt_result_t             expected_results[$];
  logic signed [VAL_W-1:0] inserted_vals[$];
  logic signed [VAL_W-1:0] value_pool[POOL_SIZE];

  // Predictor state: dense table plus live count.
  logic signed [VAL_W-1:0] table_model[CAPACITY];
  int unsigned             live_model = 0;

  int unsigned total_ops      = 0;
  int unsigned ops_sent       = 0;
  int unsigned send_gap       = 0;
  int unsigned results_seen   = 0;
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;
  bit          long_hold_done = 1'b0;
  int unsigned errors         = 0;

  function automatic int unsigned find_lowest(logic signed [VAL_W-1:0] val);
    for (int unsigned i = 0; i < live_model; i++) begin
      if (table_model[i] == val) return i;
    end
    return live_model;
  endfunction

  function automatic rmt_result_t apply_table_op(logic [1:0] cmd,
                                                 logic signed [VAL_W-1:0] val,
                                                 logic [VAL_W-1:0] rnd);
    rmt_result_t r;
    int unsigned slot;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        if (live_model >= CAPACITY) begin
          r.full_error = 1'b1;
        end else begin
          slot = find_lowest(val);
          r.success = (slot == live_model);
          table_model[live_model] = val;
          live_model++;
        end
      end
      CMD_REMOVE: begin
        slot = find_lowest(val);
        // fill the hole with the last live entry
        if (slot < live_model) begin
          table_model[slot] = table_model[live_model - 1];
          live_model--;
          r.success = 1'b1;
        end
      end
      CMD_SAMPLE: begin
        if (live_model == 0) r.empty_error = 1'b1;
        else r.sample_value = table_model[rnd % live_model];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit idling_allowed(int unsigned sent);
    return (sent + TAIL_OPS < total_ops) && ((sent / 64) % 5 != 2);
  endfunction

  task automatic add_op(rmt_cmd_e cmd, logic signed [VAL_W-1:0] val,
                        logic [VAL_W-1:0] rnd, bit drain);
    table_op_t op;
    op.cmd   = cmd;
    op.value = val;
    op.rnd   = rnd;
    op.drain = drain;
    pending_ops = {pending_ops, op};
    if (cmd == CMD_INSERT) inserted_vals = {inserted_vals, val};
  endtask

  task automatic add_random_phase(int unsigned count, int unsigned ins_pct,
                                  int unsigned rem_pct, int unsigned smp_pct);
    int unsigned             roll;
    int unsigned             pick;
    logic signed [VAL_W-1:0] val;
    rmt_cmd_e                cmd;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      if (roll < ins_pct) begin
        cmd = CMD_INSERT;
        val = (pick < 7) ? value_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
      end else if (roll < ins_pct + rem_pct) begin
        cmd = CMD_REMOVE;
        if (pick < 4) val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 8 && inserted_vals.size() != 0)
          val = inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
        else val = $urandom;
      end else if (roll < ins_pct + rem_pct + smp_pct) begin
        cmd = CMD_SAMPLE;
        val = $urandom;
      end else begin
        cmd = CMD_NOP;
        val = $urandom;
      end
      add_op(cmd, val, $urandom, n == 0);
    end
  endtask

  // Driver: predict on acceptance, hold a stalled word, then load the next one.
  always @(posedge clk_i) begin
    logic      take;
    logic      next_valid;
    table_op_t op;
    if (rst_ni) begin
      take = in_valid_i && !in_stall_o;
      if (take) begin
        expected_results = {expected_results,
                            apply_table_op(command_i, value_i, random_word_i)};
        ops_sent = ops_sent + 1;
        if (idling_allowed(ops_sent) && $urandom_range(0, 2) == 0)
          send_gap = $urandom_range(1, 4);
      end
      if (in_valid_i && !take) begin
        next_valid = 1'b1;
      end else if (send_gap > 0) begin
        send_gap   = send_gap - 1;
        next_valid = 1'b0;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].drain && expected_results.size() != 0)) begin
        op = pending_ops.pop_front();
        command_i     <= op.cmd;
        value_i       <= op.value;
        random_word_i <= op.rnd;
        next_valid = 1'b1;
      end else begin
        next_valid = 1'b0;
      end
      in_valid_i <= next_valid;
    end
  end

  // Monitor: check each accepted word against the oldest prediction, drive stall.
  always @(posedge clk_i) begin
    rmt_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected word: success %0b full %0b empty %0b sample %0d",
                   $time, success_o, full_error_o, empty_error_o, sample_value_o);
        end else begin
          want = expected_results.pop_front();
          if (success_o !== want.success) begin
            errors = errors + 1;
            $display("%0t: success expected %0b actual %0b",
                     $time, want.success, success_o);
          end
          if (full_error_o !== want.full_error) begin
            errors = errors + 1;
            $display("%0t: full_error expected %0b actual %0b",
                     $time, want.full_error, full_error_o);
          end
          if (empty_error_o !== want.empty_error) begin
            errors = errors + 1;
            $display("%0t: empty_error expected %0b actual %0b",
                     $time, want.empty_error, empty_error_o);
          end
          if (sample_value_o !== want.sample_value) begin
            errors = errors + 1;
            $display("%0t: sample_value expected %0d actual %0d",
                     $time, want.sample_value, sample_value_o);
          end
        end
        results_seen = results_seen + 1;
        if (results_seen == HOLD_AT && !long_hold_done) begin
          long_hold_done = 1'b1;
          hold_left      = LONG_HOLD;
        end
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (idling_allowed(ops_sent) && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    // Directed: empty table, extremes, duplicates, misses, moves and samples.
    add_op(CMD_SAMPLE, 32'sd0, 32'h0000_0000, 1'b0);
    add_op(CMD_REMOVE, 32'sd5, 32'h0000_0000, 1'b0);
    add_op(CMD_NOP, -32'sd1, 32'hffff_ffff, 1'b0);
    add_op(CMD_INSERT, 32'sh8000_0000, 32'h0000_0000, 1'b0);
    add_op(CMD_INSERT, 32'sh7fff_ffff, 32'hffff_ffff, 1'b0);
    add_op(CMD_INSERT, 32'sh8000_0000, 32'h0000_0000, 1'b0);
    add_op(CMD_INSERT, 32'sd0, 32'h0000_0000, 1'b0);
    add_op(CMD_INSERT, -32'sd1, 32'h0000_0000, 1'b0);
    add_op(CMD_SAMPLE, 32'sd0, 32'h0000_0000, 1'b0);
    add_op(CMD_SAMPLE, 32'sd0, 32'hffff_ffff, 1'b0);
    add_op(CMD_SAMPLE, 32'sd0, 32'h0000_0003, 1'b0);
    add_op(CMD_REMOVE, 32'sd12345, 32'h0000_0000, 1'b0);
    // lowest copy of the minimum goes, last entry moves into slot zero
    add_op(CMD_REMOVE, 32'sh8000_0000, 32'h0000_0000, 1'b0);
    // zero now sits in the last live slot
    add_op(CMD_REMOVE, 32'sd0, 32'h0000_0000, 1'b0);
    add_op(CMD_SAMPLE, 32'sd0, 32'h0000_0002, 1'b0);
    add_op(CMD_NOP, 32'sd0, 32'h0000_0000, 1'b0);
    add_op(CMD_INSERT, 32'sh5555_5555, 32'haaaa_aaaa, 1'b0);
    add_op(CMD_INSERT, 32'shaaaa_aaaa, 32'h5555_5555, 1'b0);
    add_op(CMD_REMOVE, 32'shaaaa_aaaa, 32'h0000_0000, 1'b0);
    add_op(CMD_SAMPLE, 32'sd0, 32'h8000_0000, 1'b0);
    add_op(CMD_SAMPLE, 32'sd0, $urandom, 1'b0);

    // Random: fill past capacity, mix, drain, mix.
    add_random_phase(340, 88, 5, 5);
    add_random_phase(250, 40, 35, 20);
    add_random_phase(330, 10, 78, 10);
    add_random_phase(200, 40, 35, 20);
    total_ops = pending_ops.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_ops.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
